>>> design/srmm_pkg.sv
// Package for the stencil residual mean/max unit: widths, default
// parameter values and the sequencer state type.
// No dependencies; used by stencil_residual_mean_max_unit.
`default_nettype none

package srmm_pkg;

    // Field and datapath widths
    localparam int DATA_W       = 32;  // width of every grid field and result
    localparam int SUM_W        = 48;  // running deviation sum
    localparam int PROD_W       = 64;  // multiplier product, divisor, remainder
    localparam int SHQ_W        = 48;  // dividend/quotient shift register
    localparam int STENCIL_QW   = 32;  // quotient bits of the stencil division
    localparam int DEV_QW       = 40;  // quotient bits of the density division
    localparam int DIV_CNT_W    = 6;   // step counter, holds up to SHQ_W

    // Default parameter values
    localparam int FRAC_BITS_DEF  = 24;
    localparam int MAX_POINTS_DEF = 4096;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_H,
        ST_DIV1_LOAD,
        ST_DIV1,
        ST_DIV1_END,
        ST_MUL_P,
        ST_DEV_PREP,
        ST_DIV2_LOAD,
        ST_DIV2,
        ST_DIV2_END,
        ST_ACCUM,
        ST_MEAN_LOAD,
        ST_DIV3,
        ST_OUTPUT
    } state_t;

endpackage

`default_nettype wire

>>> design/stencil_residual_mean_max_unit.sv
// Top level of the stencil residual mean/max unit: sequencer, shared
// multiplier and shared restoring divider. Depends on srmm_pkg.
`default_nettype none

// Grid points stream in on the s_ channel; for each interior point the unit
// forms the three-point second difference over the squared forward spacing,
// weights it by inverse_gamma_squared, and takes |(phipp*w - ne)/ni + 1| in
// signed fixed point with FRAC_BITS fraction bits. On the point flagged
// last_point it emits one result: the truncated mean over interior points,
// the maximum, a saturation flag and a too-few-points flag. All work runs on
// one 32x32 multiplier and one radix-2 restoring divider that retires one
// quotient bit per cycle, so s_ready is high only between items. A point that
// closes an interior point runs the stencil division (32 quotient bits), the
// density division (40 quotient bits) and setup, multiply and accumulate;
// the first two points of a grid only advance the history. The last point adds
// the mean division (48 quotient bits). A finished result waits in the output
// register while the next grid's points are already taken.
module stencil_residual_mean_max_unit #(
    parameter int FRAC_BITS  = srmm_pkg::FRAC_BITS_DEF,
    parameter int MAX_POINTS = srmm_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [srmm_pkg::DATA_W-1:0]   cfg_inverse_gamma_squared,
    // grid point input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [srmm_pkg::DATA_W-1:0] s_position,
    input  wire logic signed [srmm_pkg::DATA_W-1:0] s_potential,
    input  wire logic signed [srmm_pkg::DATA_W-1:0] s_electron_density,
    input  wire logic signed [srmm_pkg::DATA_W-1:0] s_ion_density,
    input  wire logic                          s_last_point,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [srmm_pkg::DATA_W-1:0]        m_mean_error,
    output logic [srmm_pkg::DATA_W-1:0]        m_max_error,
    output logic                               m_saturated,
    output logic                               m_too_few_points
);

    localparam int DW     = srmm_pkg::DATA_W;
    localparam int PW     = $clog2(MAX_POINTS + 1);
    localparam int D2W    = DW + 2;                 // second difference
    localparam int NUM1_W = D2W + 2 * FRAC_BITS;    // stencil dividend
    localparam int HI1_W  = NUM1_W - srmm_pkg::STENCIL_QW;
    localparam int PRW    = srmm_pkg::PROD_W;
    localparam int SHQW   = srmm_pkg::SHQ_W;
    localparam int SUMW   = srmm_pkg::SUM_W;
    localparam int Q1W    = srmm_pkg::STENCIL_QW;
    localparam int Q2W    = srmm_pkg::DEV_QW;
    localparam int CW     = srmm_pkg::DIV_CNT_W;
    localparam int VW     = Q2W + 1;                // deviation before saturation

    localparam logic [DW-1:0]   POS_LIMIT = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]   NEG_LIMIT = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0]   DEV_MAX   = {DW{1'b1}};
    localparam logic [SUMW-1:0] SUM_MAX   = {SUMW{1'b1}};
    localparam logic [VW-1:0]   ONE_F     = VW'(1) << FRAC_BITS;

    srmm_pkg::state_t state_reg, state_next;

    // configuration and grid state
    logic [DW-1:0]        igs_reg;
    logic signed [DW-1:0] phi_pp_reg, phi_p_reg, pos_p_reg, ne_p_reg, ni_p_reg;
    logic [PW-1:0]        points_reg;
    logic [SUMW-1:0]      sum_reg;
    logic [DW-1:0]        max_reg;
    logic                 ovf_reg;
    logic                 last_reg;

    // per-point work registers
    logic signed [D2W-1:0] d2_reg;
    logic [DW-1:0]         hm_reg;
    logic signed [DW-1:0]  wk_ne_reg, wk_ni_reg;
    logic [PRW-1:0]        prod_reg;
    logic [DW-1:0]         phipp_mag_reg;
    logic                  phipp_neg_reg;
    logic [PRW-1:0]        mn_reg;
    logic                  sn_reg;
    logic                  dev_neg_reg;
    logic [DW-1:0]         dev_reg;

    // shared divider
    logic [PRW-1:0]  rem_reg;
    logic [SHQW-1:0] shq_reg;
    logic [PRW-1:0]  div_d_reg;
    logic [CW-1:0]   cnt_reg;

    // output register
    logic            m_valid_reg;
    logic [DW-1:0]   m_mean_reg, m_max_reg;
    logic            m_sat_reg, m_few_reg;

    logic s_accept, out_free, interior;

    // ------------------------------------------------------------------
    // Handshake decode
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign interior  = points_reg >= PW'(2);
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Stencil terms taken at accept
    logic signed [D2W-1:0] d2_next;
    logic signed [DW:0]    dx;
    logic [DW-1:0]         hm_next;

    always_comb begin
        d2_next = {{2{s_potential[DW-1]}}, s_potential}
                - {phi_p_reg[DW-1], phi_p_reg, 1'b0}
                + {{2{phi_pp_reg[DW-1]}}, phi_pp_reg};
        dx      = {s_position[DW-1], s_position} - {pos_p_reg[DW-1], pos_p_reg};
        hm_next = dx[DW] ? DW'(-dx) : dx[DW-1:0];
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand select
    logic [DW-1:0]  mul_a, mul_b;
    logic [PRW-1:0] mul_p;

    always_comb begin
        if (state_reg == srmm_pkg::ST_MUL_H) begin
            mul_a = hm_reg;
            mul_b = hm_reg;
        end else begin
            mul_a = phipp_mag_reg;
            mul_b = igs_reg;
        end
        mul_p = mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // Stencil division setup: |d2| * 2^(2F) split into high and low parts
    logic [D2W-1:0]    d2_mag;
    logic [NUM1_W-1:0] num1;
    logic [PRW-1:0]    hi1;
    logic [DW-1:0]     limit1;
    logic              d1_zero, d1_ovf;

    always_comb begin
        d2_mag  = d2_reg[D2W-1] ? D2W'(-d2_reg) : D2W'(d2_reg);
        num1    = {{(NUM1_W-D2W){1'b0}}, d2_mag} << (2 * FRAC_BITS);
        hi1     = {{(PRW-HI1_W){1'b0}}, num1[NUM1_W-1:Q1W]};
        limit1  = d2_reg[D2W-1] ? NEG_LIMIT : POS_LIMIT;
        d1_zero = d2_mag == '0;
        // a zero spacing also lands here since hi1 >= 0
        d1_ovf  = hi1 >= prod_reg;
    end

    // ------------------------------------------------------------------
    // Numerator of the density division in sign-magnitude form
    logic [PRW-1:0] ne_mag, mb, msum;
    logic [PRW:0]   mdiff;
    logic           sa, sb;
    logic [PRW-1:0] mn_next;
    logic           sn_next;

    always_comb begin
        ne_mag = {{(PRW-DW){1'b0}}, (wk_ne_reg[DW-1] ? DW'(-wk_ne_reg) : wk_ne_reg)};
        mb     = ne_mag << FRAC_BITS;
        sa     = phipp_neg_reg && (prod_reg != '0);
        sb     = !wk_ne_reg[DW-1] && (wk_ne_reg != '0);
        msum   = prod_reg + mb;
        mdiff  = {1'b0, prod_reg} - {1'b0, mb};
        if (sa == sb) begin
            mn_next = msum;
            sn_next = sa;
        end else if (!mdiff[PRW]) begin
            mn_next = mdiff[PRW-1:0];
            sn_next = sa;
        end else begin
            mn_next = PRW'(-mdiff);
            sn_next = sb;
        end
    end

    // ------------------------------------------------------------------
    // Density division setup and deviation from its quotient
    logic [PRW-1:0] ni_mag, hi2;
    logic           d2_ovf;
    logic [VW-1:0]  qm, dev_v;
    logic           dev_sat;

    always_comb begin
        ni_mag  = {{(PRW-DW){1'b0}}, (wk_ni_reg[DW-1] ? DW'(-wk_ni_reg) : wk_ni_reg)};
        hi2     = {{(PRW-(PRW-Q2W)){1'b0}}, mn_reg[PRW-1:Q2W]};
        // zero ion density also lands here since hi2 >= 0
        d2_ovf  = hi2 >= ni_mag;
        qm      = {1'b0, shq_reg[Q2W-1:0]};
        if (!dev_neg_reg) begin
            dev_v = qm + ONE_F;
        end else if (qm >= ONE_F) begin
            dev_v = qm - ONE_F;
        end else begin
            dev_v = ONE_F - qm;
        end
        dev_sat = dev_v[VW-1:DW] != '0;
    end

    // ------------------------------------------------------------------
    // Divider step: one quotient bit per cycle
    logic [PRW:0]    rem_shift, rem_diff;
    logic            q_bit;
    logic [PRW-1:0]  rem_step;
    logic [SHQW-1:0] shq_step;

    always_comb begin
        rem_shift = {rem_reg, shq_reg[SHQW-1]};
        rem_diff  = rem_shift - {1'b0, div_d_reg};
        q_bit     = !rem_diff[PRW];
        rem_step  = q_bit ? rem_diff[PRW-1:0] : rem_shift[PRW-1:0];
        shq_step  = {shq_reg[SHQW-2:0], q_bit};
    end

    // ------------------------------------------------------------------
    // Accumulate terms
    logic [SUMW:0] sum_ext;
    logic [DW-1:0] q1;

    always_comb begin
        sum_ext = {1'b0, sum_reg} + {{(SUMW+1-DW){1'b0}}, dev_reg};
        q1      = shq_reg[Q1W-1:0];
    end

    // ------------------------------------------------------------------
    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srmm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (interior) begin
                        state_next = srmm_pkg::ST_MUL_H;
                    end else if (s_last_point) begin
                        state_next = srmm_pkg::ST_MEAN_LOAD;
                    end
                end
            end
            srmm_pkg::ST_MUL_H:     state_next = srmm_pkg::ST_DIV1_LOAD;
            srmm_pkg::ST_DIV1_LOAD: begin
                if (d1_zero || d1_ovf) begin
                    state_next = srmm_pkg::ST_MUL_P;
                end else begin
                    state_next = srmm_pkg::ST_DIV1;
                end
            end
            srmm_pkg::ST_DIV1: begin
                if (cnt_reg == CW'(1)) begin
                    state_next = srmm_pkg::ST_DIV1_END;
                end
            end
            srmm_pkg::ST_DIV1_END:  state_next = srmm_pkg::ST_MUL_P;
            srmm_pkg::ST_MUL_P:     state_next = srmm_pkg::ST_DEV_PREP;
            srmm_pkg::ST_DEV_PREP:  state_next = srmm_pkg::ST_DIV2_LOAD;
            srmm_pkg::ST_DIV2_LOAD: begin
                if (d2_ovf) begin
                    state_next = srmm_pkg::ST_ACCUM;
                end else begin
                    state_next = srmm_pkg::ST_DIV2;
                end
            end
            srmm_pkg::ST_DIV2: begin
                if (cnt_reg == CW'(1)) begin
                    state_next = srmm_pkg::ST_DIV2_END;
                end
            end
            srmm_pkg::ST_DIV2_END:  state_next = srmm_pkg::ST_ACCUM;
            srmm_pkg::ST_ACCUM: begin
                state_next = last_reg ? srmm_pkg::ST_MEAN_LOAD : srmm_pkg::ST_IDLE;
            end
            srmm_pkg::ST_MEAN_LOAD: begin
                if (points_reg < PW'(3)) begin
                    state_next = srmm_pkg::ST_OUTPUT;
                end else begin
                    state_next = srmm_pkg::ST_DIV3;
                end
            end
            srmm_pkg::ST_DIV3: begin
                if (cnt_reg == CW'(1)) begin
                    state_next = srmm_pkg::ST_OUTPUT;
                end
            end
            srmm_pkg::ST_OUTPUT: begin
                if (out_free) begin
                    state_next = srmm_pkg::ST_IDLE;
                end
            end
            default: state_next = srmm_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs
    always_comb begin
        s_ready          = state_reg == srmm_pkg::ST_IDLE;
        m_valid          = m_valid_reg;
        m_mean_error     = m_mean_reg;
        m_max_error      = m_max_reg;
        m_saturated      = m_sat_reg;
        m_too_few_points = m_few_reg;
    end

    // ------------------------------------------------------------------
    // Control and grid state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srmm_pkg::ST_IDLE;
            igs_reg     <= '0;
            phi_pp_reg  <= '0;
            phi_p_reg   <= '0;
            pos_p_reg   <= '0;
            ne_p_reg    <= '0;
            ni_p_reg    <= '0;
            points_reg  <= '0;
            sum_reg     <= '0;
            max_reg     <= '0;
            ovf_reg     <= 1'b0;
            last_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // write the weight register
            if (cfg_valid && cfg_ready) begin
                igs_reg <= cfg_inverse_gamma_squared;
            end

            // raise valid on a new result, drop it once taken
            if (state_reg == srmm_pkg::ST_OUTPUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                srmm_pkg::ST_IDLE: begin
                    // advance the history and the point count
                    if (s_accept) begin
                        phi_pp_reg <= phi_p_reg;
                        phi_p_reg  <= s_potential;
                        pos_p_reg  <= s_position;
                        ne_p_reg   <= s_electron_density;
                        ni_p_reg   <= s_ion_density;
                        last_reg   <= s_last_point;
                        if (points_reg == PW'(MAX_POINTS)) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            points_reg <= points_reg + PW'(1);
                        end
                    end
                end
                srmm_pkg::ST_DIV1_LOAD: begin
                    cnt_reg <= CW'(Q1W);
                    if (!d1_zero && d1_ovf) begin
                        ovf_reg <= 1'b1;
                    end
                end
                srmm_pkg::ST_DIV1_END: begin
                    if (q1 > limit1) begin
                        ovf_reg <= 1'b1;
                    end
                end
                srmm_pkg::ST_DIV2_LOAD: begin
                    cnt_reg <= CW'(Q2W);
                    if (d2_ovf) begin
                        ovf_reg <= 1'b1;
                    end
                end
                srmm_pkg::ST_DIV2_END: begin
                    if (dev_sat) begin
                        ovf_reg <= 1'b1;
                    end
                end
                srmm_pkg::ST_ACCUM: begin
                    // saturate the running sum, track the maximum
                    if (sum_ext[SUMW]) begin
                        sum_reg <= SUM_MAX;
                        ovf_reg <= 1'b1;
                    end else begin
                        sum_reg <= sum_ext[SUMW-1:0];
                    end
                    if (dev_reg > max_reg) begin
                        max_reg <= dev_reg;
                    end
                end
                srmm_pkg::ST_MEAN_LOAD: begin
                    cnt_reg <= CW'(SHQW);
                end
                srmm_pkg::ST_DIV1, srmm_pkg::ST_DIV2, srmm_pkg::ST_DIV3: begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
                srmm_pkg::ST_OUTPUT: begin
                    // hand over the result and clear the grid
                    if (out_free) begin
                        phi_pp_reg  <= '0;
                        phi_p_reg   <= '0;
                        pos_p_reg   <= '0;
                        ne_p_reg    <= '0;
                        ni_p_reg    <= '0;
                        points_reg  <= '0;
                        sum_reg     <= '0;
                        max_reg     <= '0;
                        ovf_reg     <= 1'b0;
                        last_reg    <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            srmm_pkg::ST_IDLE: begin
                // hold the previous point's densities for the deviation
                if (s_accept) begin
                    d2_reg    <= d2_next;
                    hm_reg    <= hm_next;
                    wk_ne_reg <= ne_p_reg;
                    wk_ni_reg <= ni_p_reg;
                end
            end
            srmm_pkg::ST_MUL_H: begin
                prod_reg <= mul_p;
            end
            srmm_pkg::ST_DIV1_LOAD: begin
                phipp_neg_reg <= d2_reg[D2W-1];
                rem_reg       <= hi1;
                shq_reg       <= {num1[Q1W-1:0], {(SHQW-Q1W){1'b0}}};
                div_d_reg     <= prod_reg;
                if (d1_zero) begin
                    phipp_mag_reg <= '0;
                end else if (d1_ovf) begin
                    phipp_mag_reg <= limit1;
                end
            end
            srmm_pkg::ST_DIV1_END: begin
                phipp_mag_reg <= (q1 > limit1) ? limit1 : q1;
            end
            srmm_pkg::ST_MUL_P: begin
                prod_reg <= mul_p;
            end
            srmm_pkg::ST_DEV_PREP: begin
                mn_reg <= mn_next;
                sn_reg <= sn_next;
            end
            srmm_pkg::ST_DIV2_LOAD: begin
                dev_neg_reg <= sn_reg != wk_ni_reg[DW-1];
                rem_reg     <= hi2;
                shq_reg     <= {mn_reg[Q2W-1:0], {(SHQW-Q2W){1'b0}}};
                div_d_reg   <= ni_mag;
                if (d2_ovf) begin
                    dev_reg <= DEV_MAX;
                end
            end
            srmm_pkg::ST_DIV2_END: begin
                dev_reg <= dev_sat ? DEV_MAX : dev_v[DW-1:0];
            end
            srmm_pkg::ST_MEAN_LOAD: begin
                rem_reg   <= '0;
                shq_reg   <= sum_reg;
                div_d_reg <= {{(PRW-PW){1'b0}}, points_reg - PW'(2)};
            end
            srmm_pkg::ST_DIV1, srmm_pkg::ST_DIV2, srmm_pkg::ST_DIV3: begin
                rem_reg <= rem_step;
                shq_reg <= shq_step;
            end
            srmm_pkg::ST_OUTPUT: begin
                if (out_free) begin
                    if (points_reg < PW'(3)) begin
                        m_mean_reg <= '0;
                        m_max_reg  <= '0;
                        m_few_reg  <= 1'b1;
                    end else begin
                        m_mean_reg <= shq_reg[DW-1:0];
                        m_max_reg  <= max_reg;
                        m_few_reg  <= 1'b0;
                    end
                    m_sat_reg <= ovf_reg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
